[rtl/hbp_pkg.sv]
// Package for the Huffman bit packer: sizes, input kind codes and the
// structs passed between the code table, the packer stage and the byte queue.
// No dependencies.
`default_nettype none
package hbp_pkg;

  localparam int SYMBOLS         = 128;
  localparam int MAX_CODE_LEN    = 16;
  localparam int CODE_FIELD_BITS = 16;
  localparam int BYTE_BITS       = 8;

  // Field widths of the stream words
  localparam int MODE_W  = 2;
  localparam int SYM_W   = 7;
  localparam int LENF_W  = 5;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  // Stored code width is the smaller of the two caps
  localparam int CODE_W = (MAX_CODE_LEN < CODE_FIELD_BITS) ? MAX_CODE_LEN : CODE_FIELD_BITS;
  localparam int LEN_W  = $clog2(CODE_W + 1);
  localparam int IDX_W  = (SYMBOLS > 2) ? $clog2(SYMBOLS) : 1;
  localparam int EXT_W  = 9;  // holds any symbol and SYMBOLS itself

  localparam int PEND_W = 7;
  localparam int PCNT_W = 3;
  localparam int ACC_W  = PEND_W + CODE_W;
  localparam int TOT_W  = ($clog2(ACC_W + 1) > 5) ? $clog2(ACC_W + 1) : 5;

  // Byte queue: each entry holds the one or two bytes of one item
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } tbl_rd_t;

  typedef struct packed {
    logic                 vld;
    logic                 two;
    logic [BYTE_BITS-1:0] b0;
    logic [BYTE_BITS-1:0] b1;
  } q_push_t;

  function automatic logic sym_in_range(input logic [SYM_W-1:0] sym);
    return ({{(EXT_W-SYM_W){1'b0}}, sym} < EXT_W'(SYMBOLS));
  endfunction

  function automatic logic [IDX_W-1:0] sym_index(input logic [SYM_W-1:0] sym);
    logic [EXT_W-1:0] ext;
    ext = {{(EXT_W-SYM_W){1'b0}}, sym};
    return ext[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/hbp_code_table.sv]
// Code table: one synchronous memory of codes and lengths plus per-entry
// valid bits cleared at reset. Uses hbp_pkg.
`default_nettype none
module hbp_code_table (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [hbp_pkg::IDX_W-1:0]    wr_idx,
  input  wire logic [hbp_pkg::CODE_FIELD_BITS-1:0] wr_code,
  input  wire logic [hbp_pkg::LENF_W-1:0]   wr_len,
  input  wire logic [hbp_pkg::IDX_W-1:0]    rd_idx,
  output hbp_pkg::tbl_rd_t                  rd_data
);

  logic [hbp_pkg::CODE_W+hbp_pkg::LEN_W-1:0] mem [hbp_pkg::SYMBOLS];
  logic [hbp_pkg::SYMBOLS-1:0]               vld_r;
  logic [hbp_pkg::CODE_W+hbp_pkg::LEN_W-1:0] rd_word_r;
  logic                                      rd_vld_r;

  logic [hbp_pkg::LEN_W-1:0]  sat_len;
  logic [hbp_pkg::CODE_W-1:0] mask;
  logic [hbp_pkg::CODE_W-1:0] wr_code_m;

  // Saturate the length and drop code bits above it
  always_comb begin
    if (wr_len > hbp_pkg::LENF_W'(hbp_pkg::CODE_W)) begin
      sat_len = hbp_pkg::LEN_W'(hbp_pkg::CODE_W);
    end else begin
      sat_len = hbp_pkg::LEN_W'(wr_len);
    end
    for (int i = 0; i < hbp_pkg::CODE_W; i++) begin
      mask[i] = (i < int'(sat_len));
    end
    wr_code_m = wr_code[hbp_pkg::CODE_W-1:0] & mask;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_code_m, sat_len};
    end
    rd_word_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_idx];
    end
  end

  // An entry never loaded reads as an empty code
  assign rd_data = rd_vld_r ? hbp_pkg::tbl_rd_t'(rd_word_r) : '0;

endmodule
`default_nettype wire

[rtl/hbp_packer.sv]
// Packer stage: merges a looked-up code with the pending bits and emits up
// to two bytes per item; a flush pads out the pending bits. Uses hbp_pkg.
`default_nettype none
module hbp_packer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       take,
  input  wire logic [hbp_pkg::MODE_W-1:0] mode,
  input  hbp_pkg::tbl_rd_t                rd_data,
  output logic                            busy,
  output hbp_pkg::q_push_t                push
);

  logic                        s1_vld_r;
  logic [hbp_pkg::MODE_W-1:0]  s1_mode_r;
  logic [hbp_pkg::PEND_W-1:0]  pend_bits_r, pend_bits_nxt;
  logic [hbp_pkg::PCNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;

  logic [hbp_pkg::ACC_W-1:0]   acc;
  logic [hbp_pkg::TOT_W-1:0]   total;
  logic [hbp_pkg::TOT_W-1:0]   rem;
  logic                        one, two;
  logic [hbp_pkg::PEND_W-1:0]  rem_mask;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else begin
      s1_vld_r    <= take;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_mode_r <= mode;
    end
  end

  always_comb begin
    acc   = (hbp_pkg::ACC_W'(pend_bits_r) << rd_data.len) | hbp_pkg::ACC_W'(rd_data.code);
    total = hbp_pkg::TOT_W'(pend_cnt_r) + hbp_pkg::TOT_W'(rd_data.len);
    two   = (total >= hbp_pkg::TOT_W'(16));
    one   = (total >= hbp_pkg::TOT_W'(8));
    if (two) begin
      rem = total - hbp_pkg::TOT_W'(16);
    end else if (one) begin
      rem = total - hbp_pkg::TOT_W'(8);
    end else begin
      rem = total;
    end
    for (int i = 0; i < hbp_pkg::PEND_W; i++) begin
      rem_mask[i] = (i < int'(rem[hbp_pkg::PCNT_W-1:0]));
    end

    push          = '0;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (s1_vld_r) begin
      case (s1_mode_r)
        hbp_pkg::MODE_ENCODE: begin
          push.vld      = one;
          push.two      = two;
          push.b0       = 8'(acc >> (total - hbp_pkg::TOT_W'(8)));
          push.b1       = 8'(acc >> (total - hbp_pkg::TOT_W'(16)));
          pend_bits_nxt = acc[hbp_pkg::PEND_W-1:0] & rem_mask;
          pend_cnt_nxt  = rem[hbp_pkg::PCNT_W-1:0];
        end
        hbp_pkg::MODE_FLUSH: begin
          // pad the partial byte with zeros at its low end
          push.vld      = (pend_cnt_r != '0);
          push.b0       = 8'({1'b0, pend_bits_r} << (4'd8 - {1'b0, pend_cnt_r}));
          pend_bits_nxt = '0;
          pend_cnt_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign busy = s1_vld_r;

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && s1_mode_r == hbp_pkg::MODE_FLUSH) |=> (pend_cnt_r == '0))
    else $error("pending bits survive a flush");

  a_two_implies_one: assert property (@(posedge clk) disable iff (!rst_n)
    (push.two) |-> (push.vld && s1_mode_r == hbp_pkg::MODE_ENCODE))
    else $error("second byte without first");

endmodule
`default_nettype wire

[rtl/hbp_out_queue.sv]
// Output queue: small register FIFO of one- or two-byte entries feeding the
// master stream side one byte per handshake. Uses hbp_pkg.
`default_nettype none
module hbp_out_queue (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  hbp_pkg::q_push_t                   push,
  output logic [hbp_pkg::Q_CNT_W-1:0]        level,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [hbp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast
);

  logic                             two_q [hbp_pkg::Q_DEPTH];
  logic [hbp_pkg::BYTE_BITS-1:0]    b0_q  [hbp_pkg::Q_DEPTH];
  logic [hbp_pkg::BYTE_BITS-1:0]    b1_q  [hbp_pkg::Q_DEPTH];
  logic [hbp_pkg::Q_PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [hbp_pkg::Q_CNT_W-1:0]      cnt_r;
  logic                             half_r;
  logic                             fire, pop;

  assign out_tvalid = (cnt_r != '0);
  assign out_tlast  = !two_q[rd_ptr_r] || half_r;
  assign out_tdata  = half_r ? b1_q[rd_ptr_r] : b0_q[rd_ptr_r];
  assign fire       = out_tvalid && out_tready;
  assign pop        = fire && out_tlast;
  assign level      = cnt_r;

  always_ff @(posedge clk) begin
    if (push.vld) begin
      two_q[wr_ptr_r] <= push.two;
      b0_q[wr_ptr_r]  <= push.b0;
      b1_q[wr_ptr_r]  <= push.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      half_r   <= 1'b0;
    end else begin
      if (push.vld) begin
        wr_ptr_r <= wr_ptr_r + hbp_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + hbp_pkg::Q_PTR_W'(1);
        half_r   <= 1'b0;
      end else if (fire) begin
        half_r   <= 1'b1;
      end
      cnt_r <= cnt_r + hbp_pkg::Q_CNT_W'(push.vld) - hbp_pkg::Q_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> (cnt_r != hbp_pkg::Q_CNT_W'(hbp_pkg::Q_DEPTH) || pop))
    else $error("byte queue overflow");

  a_second_byte_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !out_tlast) |=> (out_tvalid && out_tlast))
    else $error("second byte of an entry lost");

endmodule
`default_nettype wire

[rtl/huffman_bit_packer.sv]
// Top level of the Huffman bit packer: code table memory, packer stage and
// output byte queue. Depends on hbp_pkg, hbp_code_table, hbp_packer, hbp_out_queue.
//
//   channel  dir  tdata                                   tuser      tlast
//   in_      in   symbol, code_bits, code_len (32 bits)   mode (2)   -
//   out_     out  out_byte (8 bits)                       -          last
//
// Flow: one input word per cycle while in_tready is high. The table read is
// registered at the accept edge and merged with the pending bits in the
// cycle after, and the bytes are registered into the byte queue. Each word
// can emit up to two bytes, drained one byte a cycle while out_tready is high.
// Reset: synchronous rst_n clears the per-entry valid bits at once, so no
// clearing pass is needed; unloaded symbols read as empty codes.
// Stalls: in_tready drops when the four-entry byte queue, counting the word
// in the packer stage, has no room left for another word's bytes.
`default_nettype none
module huffman_bit_packer (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // in_tdata: symbol[6:0], code_bits[22:7], code_len[27:23], zero[31:28]
  input  wire logic [hbp_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: mode[1:0]
  input  wire logic [hbp_pkg::MODE_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_tdata: out_byte[7:0]
  output logic [hbp_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                   out_tlast
);

  logic [hbp_pkg::SYM_W-1:0]           in_symbol;
  logic [hbp_pkg::CODE_FIELD_BITS-1:0] in_code_bits;
  logic [hbp_pkg::LENF_W-1:0]          in_code_len;
  logic                                in_fire;
  logic                                in_range;
  logic                                load_wr;
  logic                                take;
  logic                                busy;
  logic [hbp_pkg::Q_CNT_W-1:0]         q_level;
  hbp_pkg::tbl_rd_t                    rd_data;
  hbp_pkg::q_push_t                    push;

  // unpack the input word
  assign in_symbol    = in_tdata[6:0];
  assign in_code_bits = in_tdata[22:7];
  assign in_code_len  = in_tdata[27:23];

  // hold off new words unless the queue can take this word's bytes
  // on top of whatever the packer stage is about to push
  assign in_tready = ({1'b0, q_level} + {{hbp_pkg::Q_CNT_W{1'b0}}, busy})
                     < (hbp_pkg::Q_CNT_W+1)'(hbp_pkg::Q_DEPTH);
  assign in_fire   = in_tvalid && in_tready;
  assign in_range  = hbp_pkg::sym_in_range(in_symbol);

  // loads write the table at the accept edge; out-of-range symbols drop
  assign load_wr = in_fire && (in_tuser == hbp_pkg::MODE_LOAD) && in_range;

  // advance encodes of known symbols and flushes into the packer stage
  assign take = in_fire &&
                (((in_tuser == hbp_pkg::MODE_ENCODE) && in_range) ||
                 (in_tuser == hbp_pkg::MODE_FLUSH));

  hbp_code_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (load_wr),
    .wr_idx  (hbp_pkg::sym_index(in_symbol)),
    .wr_code (in_code_bits),
    .wr_len  (in_code_len),
    .rd_idx  (hbp_pkg::sym_index(in_symbol)),
    .rd_data (rd_data)
  );

  hbp_packer u_packer (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .mode    (in_tuser),
    .rd_data (rd_data),
    .busy    (busy),
    .push    (push)
  );

  hbp_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .level      (q_level),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (q_level == hbp_pkg::Q_CNT_W'(hbp_pkg::Q_DEPTH)) |-> !in_tready)
    else $error("input accepted with a full byte queue");

endmodule
`default_nettype wire
